/* src/hlbc_pkg.sv */
`default_nettype none
package hlbc_pkg;

   localparam int DEFAULT_SLOTS   = 32;
   localparam int DEFAULT_BUCKETS = 13;
   localparam int BW              = 4;     // bucket id width
   localparam int REFS_W          = 8;
   localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;

   localparam logic [1:0] ACT_GET     = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_PIN     = 2'd2;
   localparam logic [1:0] ACT_UNPIN   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_ZERO    = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  device_id;
      logic [31:0] block_number;
      logic [4:0]  buffer_index;
   } req_type;

   typedef struct packed {
      logic [4:0] slot;
      logic       hit;
      logic       needs_fill;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      RSP_NONE = 3'd0,
      RSP_IDX  = 3'd1,
      RSP_HIT  = 3'd2,
      RSP_FULL = 3'd3,
      RSP_FILL = 3'd4
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         mod_step;
      logic         cnt_clr;
      logic         found_clr;
      logic         hit_step;
      logic         vic_step;
      logic         hit_commit;
      logic         mru_step;
      logic         fill_commit;
      logic         idx_op;
      rsp_kind_type rsp;
   } cmd_type;

   typedef struct packed {
      logic mod_last;
      logic scan_last;
      logic found;
      logic steal;
      logic rel_zero;
      logic rsp_busy;
   } stat_type;

endpackage
`default_nettype wire

/* src/hlbc_ctrl.sv */
`default_nettype none
module hlbc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_action,
   input  wire hlbc_pkg::stat_type stat,
   output hlbc_pkg::cmd_type      cmd
);
   import hlbc_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MOD    = 9'b000000010,
      S_HIT    = 9'b000000100,
      S_HITCHK = 9'b000001000,
      S_VIC    = 9'b000010000,
      S_VICCHK = 9'b000100000,
      S_MRU    = 9'b001000000,
      S_FILL   = 9'b010000000,
      S_IDX    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      mru_get_ff, mru_get_in;

   assign req_ready = (state_ff == S_IDLE) && !stat.rsp_busy;

   always_comb begin
      cmd        = '0;
      cmd.rsp    = RSP_NONE;
      state_in   = state_ff;
      mru_get_in = mru_get_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = (req_action == ACT_GET) ? S_MOD : S_IDX;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) begin
               cmd.cnt_clr   = 1'b1;
               cmd.found_clr = 1'b1;
               state_in      = S_HIT;
            end
         end
         S_HIT: begin
            cmd.hit_step = 1'b1;
            if (stat.scan_last) state_in = S_HITCHK;
         end
         S_HITCHK: begin
            if (stat.found) begin
               cmd.hit_commit = 1'b1;
               cmd.rsp        = RSP_HIT;
               state_in       = S_IDLE;
            end else begin
               cmd.cnt_clr   = 1'b1;
               cmd.found_clr = 1'b1;
               state_in      = S_VIC;
            end
         end
         S_VIC: begin
            cmd.vic_step = 1'b1;
            if (stat.scan_last) state_in = S_VICCHK;
         end
         S_VICCHK: begin
            if (!stat.found) begin
               cmd.rsp  = RSP_FULL;
               state_in = S_IDLE;
            end else if (stat.steal) begin
               cmd.cnt_clr = 1'b1;
               mru_get_in  = 1'b1;
               state_in    = S_MRU;
            end else begin
               state_in = S_FILL;
            end
         end
         S_MRU: begin
            cmd.mru_step = 1'b1;
            if (stat.scan_last) state_in = mru_get_ff ? S_FILL : S_IDLE;
         end
         S_FILL: begin
            cmd.fill_commit = 1'b1;
            cmd.rsp         = RSP_FILL;
            state_in        = S_IDLE;
         end
         S_IDX: begin
            cmd.idx_op = 1'b1;
            cmd.rsp    = RSP_IDX;
            if (stat.rel_zero) begin
               cmd.cnt_clr = 1'b1;
               mru_get_in  = 1'b0;
               state_in    = S_MRU;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mru_get_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mru_get_ff <= mru_get_in;
      end
   end

endmodule
`default_nettype wire

/* src/hlbc_datapath.sv */
`default_nettype none
module hlbc_datapath #(
   parameter int SLOTS   = hlbc_pkg::DEFAULT_SLOTS,
   parameter int BUCKETS = hlbc_pkg::DEFAULT_BUCKETS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hlbc_pkg::req_type  req_data,
   input  wire hlbc_pkg::cmd_type  cmd,
   output hlbc_pkg::stat_type      stat,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output hlbc_pkg::rsp_type       rsp_data
);
   import hlbc_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [7:0]        dev_ff    [SLOTS];
   logic [31:0]       blk_ff    [SLOTS];
   logic [REFS_W-1:0] refs_ff   [SLOTS];
   logic              valid_ff  [SLOTS];
   logic [BW-1:0]     bucket_ff [SLOTS];
   logic [IW-1:0]     rank_ff   [SLOTS];

   req_type           req_ff;
   logic [31:0]       modsh_ff;
   logic [2:0]        mcnt_ff;
   logic [BW-1:0]     rem_ff, rem_in;
   logic [IW-1:0]     cnt_ff;
   logic              found_ff;
   logic [IW-1:0]     fidx_ff;
   logic [IW-1:0]     frank_ff;
   logic [BW:0]       fdist_ff;
   logic              fvalid_ff;
   logic [REFS_W-1:0] frefs_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic [1:0]        idx_status;

   logic [IW-1:0]     tgt, rd_addr;
   logic              tgt_ok;
   logic [7:0]        dev_rd;
   logic [31:0]       blk_rd;
   logic [REFS_W-1:0] refs_rd;
   logic              valid_rd;
   logic [BW-1:0]     bucket_rd;
   logic [IW-1:0]     rank_rd;
   logic              hit_take, vic_take;
   logic [BW:0]       b5, r5, bkt_gap;

   assign tgt      = IW'(req_ff.buffer_index);
   assign tgt_ok   = int'(req_ff.buffer_index) < SLOTS;
   assign rd_addr  = cmd.idx_op ? tgt : cnt_ff;
   assign dev_rd    = dev_ff[rd_addr];
   assign blk_rd    = blk_ff[rd_addr];
   assign refs_rd   = refs_ff[rd_addr];
   assign valid_rd  = valid_ff[rd_addr];
   assign bucket_rd = bucket_ff[rd_addr];
   assign rank_rd   = rank_ff[rd_addr];

   // block mod BUCKETS, four bits per cycle from the top
   always_comb begin
      logic [BW:0] r;
      r = {1'b0, rem_ff};
      for (int k = 0; k < 4; k++) begin
         r = {r[BW-1:0], modsh_ff[31-k]};
         if (r >= (BW+1)'(BUCKETS)) r = r - (BW+1)'(BUCKETS);
      end
      rem_in = r[BW-1:0];
   end

   // cyclic distance of the slot's bucket past the request bucket
   assign b5      = {1'b0, bucket_rd};
   assign r5      = {1'b0, rem_ff};
   assign bkt_gap = (b5 >= r5) ? (b5 - r5) : (b5 + (BW+1)'(BUCKETS) - r5);

   assign hit_take = (bucket_rd == rem_ff) && (dev_rd == req_ff.device_id) &&
                     (blk_rd == req_ff.block_number) &&
                     (!found_ff || rank_rd > frank_ff);

   // own bucket: least recent; other buckets: nearest, then most recent
   assign vic_take = (refs_rd == '0) &&
                     (!found_ff || bkt_gap < fdist_ff ||
                      (bkt_gap == fdist_ff &&
                       ((bkt_gap == '0) ? (rank_rd < frank_ff) : (rank_rd > frank_ff))));

   always_comb begin
      idx_status = ST_OK;
      if (tgt_ok && req_ff.action != ACT_PIN && refs_rd == '0) idx_status = ST_ZERO;
   end

   assign stat.mod_last  = (mcnt_ff == 3'd7);
   assign stat.scan_last = (cnt_ff == IW'(SLOTS - 1));
   assign stat.found     = found_ff;
   assign stat.steal     = (fdist_ff != '0);
   assign stat.rel_zero  = cmd.idx_op && tgt_ok && (req_ff.action == ACT_RELEASE) &&
                           (refs_rd == REFS_W'(1));
   assign stat.rsp_busy  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         modsh_ff <= req_data.block_number;
         mcnt_ff  <= '0;
         rem_ff   <= '0;
      end
      if (cmd.mod_step) begin
         modsh_ff <= {modsh_ff[27:0], 4'd0};
         mcnt_ff  <= mcnt_ff + 3'd1;
         rem_ff   <= rem_in;
      end
      if (cmd.cnt_clr) cnt_ff <= '0;
      else if (cmd.hit_step || cmd.vic_step || cmd.mru_step) cnt_ff <= cnt_ff + IW'(1);
      if (cmd.found_clr) found_ff <= 1'b0;
      if ((cmd.hit_step && hit_take) || (cmd.vic_step && vic_take)) begin
         found_ff  <= 1'b1;
         fidx_ff   <= cnt_ff;
         frank_ff  <= rank_rd;
         fdist_ff  <= cmd.vic_step ? bkt_gap : '0;
         fvalid_ff <= valid_rd;
         frefs_ff  <= refs_rd;
      end
      if (cmd.idx_op) begin
         fidx_ff  <= tgt;
         frank_ff <= rank_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            dev_ff[i]    <= '0;
            blk_ff[i]    <= '0;
            refs_ff[i]   <= '0;
            valid_ff[i]  <= 1'b0;
            bucket_ff[i] <= BW'(i % BUCKETS);
            rank_ff[i]   <= IW'(i);
         end
      end else begin
         if (cmd.hit_commit) begin
            if (frefs_ff != REFS_MAX) refs_ff[fidx_ff] <= frefs_ff + REFS_W'(1);
            valid_ff[fidx_ff] <= 1'b1;
         end
         if (cmd.mru_step) begin
            if (cnt_ff == fidx_ff) rank_ff[cnt_ff] <= IW'(SLOTS - 1);
            else if (rank_rd > frank_ff) rank_ff[cnt_ff] <= rank_rd - IW'(1);
         end
         if (cmd.fill_commit) begin
            dev_ff[fidx_ff]    <= req_ff.device_id;
            blk_ff[fidx_ff]    <= req_ff.block_number;
            refs_ff[fidx_ff]   <= REFS_W'(1);
            valid_ff[fidx_ff]  <= 1'b1;
            bucket_ff[fidx_ff] <= rem_ff;
         end
         if (cmd.idx_op && tgt_ok) begin
            if (req_ff.action == ACT_PIN) begin
               if (refs_rd != REFS_MAX) refs_ff[tgt] <= refs_rd + REFS_W'(1);
            end else if (refs_rd != '0) begin
               refs_ff[tgt] <= refs_rd - REFS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.rsp)
         RSP_IDX:  rsp_ff <= '{slot: req_ff.buffer_index, hit: 1'b0,
                               needs_fill: 1'b0, status: idx_status};
         RSP_HIT:  rsp_ff <= '{slot: 5'(fidx_ff), hit: 1'b1,
                               needs_fill: !fvalid_ff, status: ST_OK};
         RSP_FULL: rsp_ff <= '{slot: 5'd0, hit: 1'b0,
                               needs_fill: 1'b0, status: ST_NO_FREE};
         RSP_FILL: rsp_ff <= '{slot: 5'(fidx_ff), hit: 1'b0,
                               needs_fill: 1'b1, status: ST_OK};
         default:  ;
      endcase
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp != RSP_NONE) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* src/hashed_lru_block_buffer_cache_core.sv */
// Get: bucket hashing, then a match scan over every slot, a victim scan over every
//   slot and, on a steal, a recency sweep over every slot before the result beat;
//   a hit ends after the match scan, a full cache after the victim scan.
// Release/pin/unpin: the index state registers the result beat; release to zero adds
//   a recency sweep over every slot before the next request is taken.
// One request in flight; the next is taken once the result beat is gone.
// Synchronous reset restores every slot descriptor at once, no clearing pass.
`default_nettype none
module hashed_lru_block_buffer_cache_core #(
   parameter int SLOTS   = hlbc_pkg::DEFAULT_SLOTS,
   parameter int BUCKETS = hlbc_pkg::DEFAULT_BUCKETS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire hlbc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output hlbc_pkg::rsp_type      rsp_data
);
   import hlbc_pkg::*;

   // controller sequences scans; datapath holds slot table and result beat
   cmd_type  cmd;
   stat_type stat;

   hlbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_data.action),
      .stat       (stat),
      .cmd        (cmd)
   );

   hlbc_datapath #(
      .SLOTS   (SLOTS),
      .BUCKETS (BUCKETS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* src/hlbc_checker.sv */
`default_nettype none
module hlbc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire hlbc_pkg::rsp_type rsp_data
);
   import hlbc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.status == ST_OK)
      else $error("hit with error status");

   a_full_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_NO_FREE |->
         rsp_data.slot == 5'd0 && !rsp_data.hit && !rsp_data.needs_fill)
      else $error("no-free result carries a slot");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_ZERO)
      else $error("undefined status code");

endmodule

bind hashed_lru_block_buffer_cache_core hlbc_checker u_hlbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

/* tb/tb_hashed_lru_block_buffer_cache_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_hashed_lru_block_buffer_cache_core;
   import hlbc_pkg::*;

   localparam int NSLOT = DEFAULT_SLOTS;
   localparam int NBKT  = DEFAULT_BUCKETS;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   hashed_lru_block_buffer_cache_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the cache descriptors.
   logic [7:0]  sh_dev   [NSLOT];
   logic [31:0] sh_blk   [NSLOT];
   logic [7:0]  sh_refs  [NSLOT];
   logic        sh_valid [NSLOT];
   int          sh_bkt   [NSLOT];
   int          sh_rank  [NSLOT];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   bit      stim_done = 1'b0;
   int      drain_marks[$];     // beat counts at which the sender waits for drain
   int      beats_sent = 0;

   function automatic void shadow_reset();
      for (int i = 0; i < NSLOT; i++) begin
         sh_dev[i] = '0; sh_blk[i] = '0; sh_refs[i] = '0; sh_valid[i] = 1'b0;
         sh_bkt[i] = i % NBKT; sh_rank[i] = i;
      end
   endfunction

   function automatic void bump_recency(int s);
      int old;
      old = sh_rank[s];
      for (int j = 0; j < NSLOT; j++)
         if (sh_rank[j] > old) sh_rank[j]--;
      sh_rank[s] = NSLOT - 1;
   endfunction

   function automatic rsp_type predict_cache(req_type r);
      rsp_type o;
      int bid, found, other;
      o = '0;
      found = -1;
      if (r.action == ACT_GET) begin
         bid = r.block_number % NBKT;
         // hit lookup: most recent match wins
         for (int j = 0; j < NSLOT; j++)
            if (sh_bkt[j] == bid && sh_dev[j] == r.device_id && sh_blk[j] == r.block_number)
               if (found < 0 || sh_rank[j] > sh_rank[found]) found = j;
         if (found >= 0) begin
            o.slot = 5'(found); o.hit = 1'b1; o.needs_fill = !sh_valid[found];
            o.status = ST_OK;
            if (sh_refs[found] != REFS_MAX) sh_refs[found]++;
            sh_valid[found] = 1'b1;
            return o;
         end
         // local reuse: least recent free buffer, rank kept
         for (int j = 0; j < NSLOT; j++)
            if (sh_bkt[j] == bid && sh_refs[j] == 0)
               if (found < 0 || sh_rank[j] < sh_rank[found]) found = j;
         // steal: most recent free buffer of the next bucket that has one
         for (int k = 1; found < 0 && k < NBKT; k++) begin
            other = (bid + k) % NBKT;
            for (int j = 0; j < NSLOT; j++)
               if (sh_bkt[j] == other && sh_refs[j] == 0)
                  if (found < 0 || sh_rank[j] > sh_rank[found]) found = j;
            if (found >= 0) begin
               sh_bkt[found] = bid;
               bump_recency(found);
            end
         end
         if (found < 0) begin
            o.status = ST_NO_FREE;
            return o;
         end
         sh_dev[found] = r.device_id; sh_blk[found] = r.block_number;
         sh_refs[found] = 8'd1; sh_valid[found] = 1'b1;
         o.slot = 5'(found); o.needs_fill = 1'b1; o.status = ST_OK;
         return o;
      end
      o.slot = r.buffer_index;
      o.status = ST_OK;
      if (r.buffer_index < NSLOT) begin
         if (r.action == ACT_PIN) begin
            if (sh_refs[r.buffer_index] != REFS_MAX) sh_refs[r.buffer_index]++;
         end else if (sh_refs[r.buffer_index] == 0) begin
            o.status = ST_ZERO;
         end else begin
            sh_refs[r.buffer_index]--;
            if (r.action == ACT_RELEASE && sh_refs[r.buffer_index] == 0)
               bump_recency(r.buffer_index);
         end
      end
      return o;
   endfunction

   function automatic req_type mk_req(logic [1:0] act, logic [7:0] dev,
                                      logic [31:0] blk, logic [4:0] idx);
      req_type r;
      r.action = act; r.device_id = dev; r.block_number = blk; r.buffer_index = idx;
      return r;
   endfunction

   // Random content: blocks come mostly from a small pool so hits and steals occur.
   function automatic req_type rand_req();
      logic [31:0] blk;
      logic [7:0]  dev;
      int          sel;
      sel = $urandom_range(0, 99);
      blk = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 40);
      dev = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 2));
      if (sel < 45) return mk_req(ACT_GET, dev, blk, 5'($urandom_range(0, 31)));
      if (sel < 80)
         return mk_req(ACT_RELEASE, 8'($urandom()), $urandom(), 5'($urandom_range(0, 31)));
      if (sel < 88)
         return mk_req(ACT_PIN, 8'($urandom()), $urandom(), 5'($urandom_range(0, 31)));
      return mk_req(ACT_UNPIN, 8'($urandom()), $urandom(), 5'($urandom_range(0, 31)));
   endfunction

   initial begin
      shadow_reset();
      // matches and misses after reset: block 0 lives in every slot of bucket 0
      pending_reqs.push_back(mk_req(ACT_GET, 8'h00, 32'h0, 5'd0));
      pending_reqs.push_back(mk_req(ACT_GET, 8'h00, 32'h0, 5'd0));
      pending_reqs.push_back(mk_req(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31));
      pending_reqs.push_back(mk_req(ACT_GET, 8'hA5, 32'h8000_0000, 5'd0));
      // count at zero for release and unpin
      pending_reqs.push_back(mk_req(ACT_RELEASE, 8'h00, 32'h0, 5'd31));
      pending_reqs.push_back(mk_req(ACT_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd5));
      pending_reqs.push_back(mk_req(ACT_PIN, 8'h00, 32'h0, 5'd31));
      pending_reqs.push_back(mk_req(ACT_UNPIN, 8'h00, 32'h0, 5'd31));
      pending_reqs.push_back(mk_req(ACT_PIN, 8'h00, 32'h0, 5'd7));
      pending_reqs.push_back(mk_req(ACT_RELEASE, 8'h00, 32'h0, 5'd7));
      // count saturation on slot 3
      for (int i = 0; i < 260; i++) pending_reqs.push_back(mk_req(ACT_PIN, 8'h0, 32'h0, 5'd3));
      pending_reqs.push_back(mk_req(ACT_UNPIN, 8'h0, 32'h0, 5'd3));
      for (int i = 0; i < 256; i++)
         pending_reqs.push_back(mk_req(ACT_RELEASE, 8'h0, 32'h0, 5'd3));
      drain_marks.push_back(pending_reqs.size());
      // exhaust the cache: 34 distinct misses, more than there are slots
      for (int i = 0; i < NSLOT + 2; i++)
         pending_reqs.push_back(mk_req(ACT_GET, 8'h11, 32'd1000 + i, 5'd0));
      for (int i = 0; i < NSLOT; i++)
         pending_reqs.push_back(mk_req(ACT_RELEASE, 8'h0, 32'h0, i[4:0]));
      for (int i = 0; i < 260; i++)
         pending_reqs.push_back(mk_req(ACT_RELEASE, 8'h0, 32'h0, 5'($urandom_range(0, 31))));
      for (int i = 0; i < 1000; i++) pending_reqs.push_back(rand_req());
   end

   int send_wait = 0;
   bit drain_hold = 1'b0;

   // Driver: one beat at a time, random gap before each.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         beats_sent <= beats_sent + 1;
         req_valid  <= 1'b0;
         send_wait  <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end else if (!req_valid) begin
         if (drain_marks.size() != 0 && beats_sent == drain_marks[0]) begin
            if (expected_rsps.size() == 0) void'(drain_marks.pop_front());
         end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs[0];
            req_valid <= 1'b1;
            expected_rsps.push_back(predict_cache(pending_reqs.pop_front()));
         end else begin
            stim_done <= 1'b1;
         end
      end
   end

   int rsp_wait = 0;

   // Monitor: random stall per beat, then compare against the oldest prediction.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result beat slot=%0d", rsp_data.slot);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.slot != e.slot) begin
               $error("slot expected %0d actual %0d", e.slot, rsp_data.slot); errors++;
            end
            if (rsp_data.hit != e.hit) begin
               $error("hit expected %0d actual %0d", e.hit, rsp_data.hit); errors++;
            end
            if (rsp_data.needs_fill != e.needs_fill) begin
               $error("needs_fill expected %0d actual %0d", e.needs_fill,
                      rsp_data.needs_fill);
               errors++;
            end
            if (rsp_data.status != e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status); errors++;
            end
         end
         rsp_wait  <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_rsps.size() == 0 && !req_valid);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
